[design/hlr_pkg.sv]
package hlr_pkg;

  // Graph size; node sets are Nodes bits wide.
  localparam int unsigned Nodes = 64;
  localparam int unsigned NodeW = (Nodes > 1) ? $clog2(Nodes) : 1;

  // Fixed field widths of the input word.
  localparam int unsigned IdW   = 6;
  localparam int unsigned HopW  = 6;
  localparam int unsigned MaskW = 64;

  typedef logic [Nodes-1:0] set_t;
  typedef logic [NodeW-1:0] node_idx_t;
  typedef logic [IdW-1:0]   id_t;
  typedef logic [HopW-1:0]  hop_t;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  // Classification of a query at accept time.
  typedef enum logic [1:0] {
    KindBad,     // source or target out of range
    KindSame,    // source equals target
    KindZero,    // zero hop limit, distinct nodes
    KindSearch   // needs the level expansion
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEval,
    StResp
  } state_e;

  typedef struct packed {
    logic wr;        // write one adjacency row
    logic start;     // latch a query and seed the search
    logic scan;      // issue row reads for the pending frontier
    logic eval;      // close one level
    logic hold_ld;   // capture the answer
    logic hold_val;
    logic push;      // move the answer into the output register
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  pend_empty;
    logic  hit;
    logic  new_empty;
    logic  last_hop;
    logic  out_free;
  } status_t;

  function automatic logic node_ok(id_t n);
    return int'(n) < int'(Nodes);
  endfunction

endpackage

[design/hlr_ctrl.sv]
module hlr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  hlr_pkg::status_t status_i,
  output hlr_pkg::cmd_t    cmd_o
);
  import hlr_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (op_i == OpQuery)) begin
          state_d = (status_i.kind == KindSearch) ? StScan : StResp;
        end
      end
      StScan: begin
        if (status_i.pend_empty) begin
          state_d = StEval;
        end
      end
      StEval: begin
        if (status_i.hit || status_i.new_empty || status_i.last_hop) begin
          state_d = StResp;
        end else begin
          state_d = StScan;
        end
      end
      StResp: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.wr    = accept && (op_i == OpLoad);
        cmd_o.start = accept && (op_i == OpQuery);
        if (accept && (op_i == OpQuery) && (status_i.kind != KindSearch)) begin
          cmd_o.hold_ld  = 1'b1;
          cmd_o.hold_val = (status_i.kind == KindSame);
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        if (status_i.hit || status_i.new_empty || status_i.last_hop) begin
          cmd_o.hold_ld  = 1'b1;
          cmd_o.hold_val = status_i.hit;
        end
      end
      StResp: begin
        cmd_o.push = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[design/hlr_dp.sv]
module hlr_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hlr_pkg::cmd_t               cmd_i,
  output hlr_pkg::status_t            status_o,
  input  logic [hlr_pkg::IdW-1:0]     row_node_i,
  input  logic [hlr_pkg::MaskW-1:0]   row_mask_i,
  input  logic [hlr_pkg::IdW-1:0]     source_node_i,
  input  logic [hlr_pkg::IdW-1:0]     target_node_i,
  input  logic [hlr_pkg::HopW-1:0]    hop_limit_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        reachable_o
);
  import hlr_pkg::*;

  // Adjacency store with one valid bit per row; an unwritten row reads as no edges.
  set_t      adj_mem [Nodes];
  logic      row_vld_q [Nodes];
  set_t      rd_data_q;
  logic      rd_row_vld_q;
  logic      rd_pend_q;
  node_idx_t rd_idx;

  set_t pend_q, visited_q, next_q, tgt_q;
  hop_t hops_q;
  logic hold_q;
  logic out_valid_q, reach_q;

  set_t  low_bit, new_set, rd_row;
  logic  wr_en, issue;
  kind_e kind;

  assign wr_en   = cmd_i.wr && node_ok(row_node_i);
  assign issue   = cmd_i.scan && (pend_q != '0);
  assign low_bit = pend_q & (~pend_q + set_t'(1));
  assign rd_row  = rd_row_vld_q ? rd_data_q : '0;
  assign new_set = next_q & ~visited_q;

  always_comb begin
    rd_idx = '0;
    for (int i = 0; i < int'(Nodes); i++) begin
      if (low_bit[i]) begin
        rd_idx = rd_idx | node_idx_t'(i);
      end
    end
  end

  always_comb begin
    if (!node_ok(source_node_i) || !node_ok(target_node_i)) begin
      kind = KindBad;
    end else if (source_node_i == target_node_i) begin
      kind = KindSame;
    end else if (hop_limit_i == '0) begin
      kind = KindZero;
    end else begin
      kind = KindSearch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      adj_mem[row_node_i[NodeW-1:0]] <= row_mask_i[Nodes-1:0];
    end
    rd_data_q <= adj_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(Nodes); i++) begin
        row_vld_q[i] <= 1'b0;
      end
      rd_row_vld_q <= 1'b0;
      rd_pend_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[row_node_i[NodeW-1:0]] <= 1'b1;
      end
      rd_row_vld_q <= row_vld_q[rd_idx];
      rd_pend_q    <= issue;
    end
  end

  // Search state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pend_q    <= set_t'(1) << source_node_i;
      visited_q <= set_t'(1) << source_node_i;
      tgt_q     <= set_t'(1) << target_node_i;
      next_q    <= '0;
      hops_q    <= hop_limit_i;
    end else if (cmd_i.eval) begin
      pend_q    <= new_set;
      visited_q <= visited_q | new_set;
      next_q    <= '0;
      hops_q    <= hops_q - hop_t'(1);
    end else begin
      if (issue) begin
        pend_q <= pend_q & (pend_q - set_t'(1));
      end
      if (rd_pend_q) begin
        next_q <= next_q | rd_row;
      end
    end
    if (cmd_i.hold_ld) begin
      hold_q <= cmd_i.hold_val;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      reach_q <= hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reachable_o = reach_q;

  assign status_o.kind       = kind;
  assign status_o.pend_empty = (pend_q == '0);
  assign status_o.hit        = |(next_q & tgt_q);
  assign status_o.new_empty  = (new_set == '0);
  assign status_o.last_hop   = (hops_q == hop_t'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

[design/hop_limited_reachability.sv]
// Hop-limited reachability over a directed graph of up to 64 nodes. A word with
// op_i = 0 stores row_mask_i as the neighbor set of row_node_i (no
// answer); a word with op_i = 1 asks whether target_node_i is within
// hop_limit_i edges of source_node_i and gives exactly one reachable_o word.
// Source equal to target answers 1, a zero hop limit otherwise answers 0, and
// any node at or above the graph size answers 0. The search expands the graph
// level by level with a frontier and a visited set: each level reads one
// adjacency row per frontier node from the row store, one row per cycle.
// Queries run one at a time: in_ready_o drops while a search runs and
// rises again once the answer sits in the output register, so loads and the
// next query are taken while an earlier answer still waits for out_ready_i.
// Rows are empty after reset; no clearing pass is needed.
module hop_limited_reachability (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [hlr_pkg::IdW-1:0]    row_node_i,
  input  logic [hlr_pkg::MaskW-1:0]  row_mask_i,
  input  logic [hlr_pkg::IdW-1:0]    source_node_i,
  input  logic [hlr_pkg::IdW-1:0]    target_node_i,
  input  logic [hlr_pkg::HopW-1:0]   hop_limit_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       reachable_o
);
  import hlr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: idle, scan frontier, close level, hand off the answer.
  hlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Row store, frontier/visited sets and the output register.
  hlr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .row_node_i    (row_node_i),
    .row_mask_i    (row_mask_i),
    .source_node_i (source_node_i),
    .target_node_i (target_node_i),
    .hop_limit_i   (hop_limit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reachable_o   (reachable_o)
  );

  // A query holds off further input words for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == OpQuery)) |=> !in_ready_o)
    else $error("input accepted right after a query");

  // Never overwrite an answer that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!out_valid_o || out_ready_i))
    else $error("answer pushed over a pending word");

  // A level closes only after a scan whose frontier was exhausted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |-> ($past(cmd.scan) && $past(status.pend_empty)))
    else $error("level closed before the frontier scan finished");

  // Loads, query starts and answer pushes never coincide with an active search step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan || cmd.eval) |-> !(cmd.wr || cmd.start || cmd.push))
    else $error("command overlap during search");

endmodule

[dv/tb_hop_limited_reachability.sv]
`timescale 1ns / 1ps

module tb_hop_limited_reachability;
  import hlr_pkg::*;

  localparam int unsigned WordTarget    = 1250;
  localparam int unsigned HoldOffAfter  = 100;     // queries taken before the long hold-off
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned DrainCycles   = 300;     // longer than the slowest search
  localparam int unsigned ReportMax     = 10;
  localparam int unsigned LastNode      = 63;

  // One word as offered on the input channel. Rows whose answer is obvious carry it in
  // known/want; all others are answered by the reachability predictor at accept time.
  typedef struct {
    op_e              op;
    id_t              row;
    logic [MaskW-1:0] mask;
    id_t              src;
    id_t              dst;
    hop_t             hops;
    bit               known;
    logic             want;
  } graph_word_t;

  typedef enum int unsigned {
    PlanWipe,    // rebuild the whole graph sparse
    PlanChain,   // a path of mostly one-hot rows, hop limits near the target's distance
    PlanScatter, // a few sparse rows, mostly short hop limits
    PlanDense,   // full random rows, any hop limit
    PlanNoise    // fully random words
  } plan_e;

  typedef enum int unsigned {
    RxOpen,
    RxCoin,
    RxSlow
  } rx_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             reachable_o;
  graph_word_t      cur_word;

  // Predictor state: one neighbor set per node, plus the answers still owed by the block.
  set_t             graph_rows [Nodes];
  logic             answers_due [$];
  graph_word_t      word_plan [$];

  logic             in_took;
  int unsigned      errors;
  int unsigned      loads_taken;
  int unsigned      queries_taken;
  int unsigned      hits;
  int unsigned      misses;
  int unsigned      stall_run;
  int unsigned      stall_max;

  hop_limited_reachability dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (cur_word.op),
    .row_node_i    (cur_word.row),
    .row_mask_i    (cur_word.mask),
    .source_node_i (cur_word.src),
    .target_node_i (cur_word.dst),
    .hop_limit_i   (cur_word.hops),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .reachable_o   (reachable_o)
  );

  // Breadth-first expansion, one hop level per pass; stop on a hit or an empty frontier.
  function automatic logic reach_within(id_t src, id_t dst, hop_t hops);
    set_t front;
    set_t seen;
    set_t next;
    if (int'(src) >= int'(Nodes) || int'(dst) >= int'(Nodes)) return 1'b0;
    if (src == dst) return 1'b1;
    front = '0;
    front[src] = 1'b1;
    seen = front;
    for (int unsigned lvl = 0; lvl < hops; lvl++) begin
      next = '0;
      for (int unsigned n = 0; n < Nodes; n++) begin
        if (front[n]) next |= graph_rows[n];
      end
      if (next[dst]) return 1'b1;
      next &= ~seen;
      seen |= next;
      front = next;
      if (next == '0) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic logic [MaskW-1:0] bit_at(int unsigned n);
    return MaskW'(1) << (n % MaskW);
  endfunction

  function automatic logic [MaskW-1:0] rand_mask();
    return {$urandom, $urandom};
  endfunction

  // Unused fields of a word still get random values so every input bit toggles.
  function automatic graph_word_t load_w(id_t row, logic [MaskW-1:0] mask);
    graph_word_t w;
    w.op    = OpLoad;
    w.row   = row;
    w.mask  = mask;
    w.src   = id_t'($urandom);
    w.dst   = id_t'($urandom);
    w.hops  = hop_t'($urandom);
    w.known = 1'b0;
    w.want  = 1'b0;
    return w;
  endfunction

  function automatic graph_word_t query_w(id_t src, id_t dst, hop_t hops);
    graph_word_t w;
    w.op    = OpQuery;
    w.row   = id_t'($urandom);
    w.mask  = rand_mask();
    w.src   = src;
    w.dst   = dst;
    w.hops  = hops;
    w.known = 1'b0;
    w.want  = 1'b0;
    return w;
  endfunction

  function automatic graph_word_t query_known(id_t src, id_t dst, hop_t hops, logic want);
    graph_word_t w;
    w = query_w(src, dst, hops);
    w.known = 1'b1;
    w.want  = want;
    return w;
  endfunction

  // Append one word at the tail of the plan.
  function automatic void plan_add(graph_word_t w);
    word_plan.insert(word_plan.size(), w);
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= ReportMax) $display("%0t ERROR %s", $realtime, msg);
  endfunction

  // Append one random group of words to the plan.
  task automatic plan_group();
    plan_e            kind;
    int unsigned      pick;
    int               base;
    int               len;
    int               d;
    int               h;
    int               cnt;
    id_t              a;
    id_t              b;
    logic [MaskW-1:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 5)       kind = PlanWipe;
    else if (pick < 40) kind = PlanChain;
    else if (pick < 65) kind = PlanScatter;
    else if (pick < 80) kind = PlanDense;
    else                kind = PlanNoise;
    case (kind)
      PlanWipe: begin
        for (int n = 0; n <= int'(LastNode); n++) begin
          m = ($urandom_range(0, 2) == 0) ? '0 : bit_at($urandom_range(0, LastNode));
          plan_add(load_w(id_t'(n), m));
        end
      end
      PlanChain: begin
        // Link base -> base+1 -> ... with a few stray edges and breaks.
        base = $urandom_range(0, LastNode);
        len  = ($urandom_range(0, 7) == 0) ? int'(LastNode) : $urandom_range(2, 20);
        for (int k = 0; k < len; k++) begin
          m = bit_at(base + k + 1);
          if ($urandom_range(0, 3) == 0) m |= bit_at($urandom_range(0, LastNode));
          if ($urandom_range(0, 19) == 0) m = '0;
          plan_add(load_w(id_t'((base + k) % 64), m));
        end
        cnt = $urandom_range(3, 8);
        repeat (cnt) begin
          d = $urandom_range(0, len);
          h = d + int'($urandom_range(0, 2)) - 1;
          if (h < 0) h = 0;
          if (h > int'(LastNode)) h = LastNode;
          plan_add(query_w(id_t'(base), id_t'((base + d) % 64), hop_t'(h)));
        end
      end
      PlanScatter: begin
        cnt = $urandom_range(1, 8);
        repeat (cnt) begin
          m = '0;
          if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 3)) m |= bit_at($urandom_range(0, LastNode));
          end
          plan_add(load_w(id_t'($urandom), m));
        end
        cnt = $urandom_range(2, 8);
        repeat (cnt) begin
          a = id_t'($urandom);
          b = ($urandom_range(0, 7) == 0) ? a : id_t'($urandom);
          h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, LastNode) : $urandom_range(0, 10);
          plan_add(query_w(a, b, hop_t'(h)));
        end
      end
      PlanDense: begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) begin
          m = ($urandom_range(0, 4) == 0) ? '1 : rand_mask();
          plan_add(load_w(id_t'($urandom), m));
        end
        cnt = $urandom_range(2, 5);
        repeat (cnt) begin
          plan_add(query_w(id_t'($urandom), id_t'($urandom), hop_t'($urandom)));
        end
      end
      default: begin
        cnt = $urandom_range(4, 10);
        repeat (cnt) begin
          if ($urandom_range(0, 1) == 0) begin
            plan_add(load_w(id_t'($urandom), rand_mask()));
          end else begin
            plan_add(query_w(id_t'($urandom), id_t'($urandom), hop_t'($urandom)));
          end
        end
      end
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(64'd20_000_000);
    $display("tb_hop_limited_reachability: done, errors");
    $finish;
  end

  // Sample both channels at the rising edge. Check answers before queuing new ones so a
  // query taken in the same cycle never lines up against an older answer.
  always @(posedge clk_i or negedge rst_ni) begin
    logic due;
    if (!rst_ni) begin
      in_took <= 1'b0;
      foreach (graph_rows[i]) graph_rows[i] = '0;
      answers_due.delete();
      stall_run = 0;
    end else begin
      in_took <= in_valid_i && in_ready_o;

      if (out_valid_o && out_ready_i) begin
        if (answers_due.size() == 0) begin
          flag_error($sformatf("reachable_o=%b with no query pending", reachable_o));
        end else begin
          due = answers_due.pop_front();
          if (due) hits++;
          else misses++;
          if (reachable_o !== due) begin
            flag_error($sformatf("answer %0d: reachable_o expected %b, got %b",
                                 hits + misses, due, reachable_o));
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        stall_run = 0;
        if (cur_word.op == OpLoad) begin
          loads_taken++;
          // Rows past the graph size are dropped; mask bits past it are cut off.
          if (int'(cur_word.row) < int'(Nodes)) graph_rows[cur_word.row] = set_t'(cur_word.mask);
        end else begin
          queries_taken++;
          answers_due.insert(answers_due.size(), cur_word.known ? cur_word.want
                             : reach_within(cur_word.src, cur_word.dst, cur_word.hops));
        end
      end else if (in_valid_i) begin
        stall_run++;
        if (stall_run > stall_max) stall_max = stall_run;
      end
    end
  end

  // Receiver: random stall patterns, and once a long hold-off so the block backs up.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    bit          held;
    out_ready_i = 1'b0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && queries_taken >= HoldOffAfter) begin
        held = 1'b1;
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      mode = rx_mode_e'($urandom_range(0, 2));
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          RxOpen:  out_ready_i = 1'b1;
          RxCoin:  out_ready_i = 1'($urandom_range(0, 1));
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Sender: directed words first, then random groups, offered in bursts with gaps.
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned sent;
    errors        = 0;
    loads_taken   = 0;
    queries_taken = 0;
    hits          = 0;
    misses        = 0;
    stall_max     = 0;
    in_valid_i    = 1'b0;
    cur_word      = load_w('0, '0);

    // Empty graph after reset, then self-queries at both node extremes.
    plan_add(query_known(6'd0, 6'd1, 6'd63, 1'b0));
    plan_add(query_known(6'd63, 6'd63, 6'd0, 1'b1));
    plan_add(query_known(6'd0, 6'd0, 6'd63, 1'b1));
    // Node 0 reaches everything in one hop; zero hop limit still misses.
    plan_add(load_w(6'd0, '1));
    plan_add(query_w(6'd0, 6'd63, 6'd1));
    plan_add(query_known(6'd0, 6'd63, 6'd0, 1'b0));
    // Node 63 has no out edges: frontier empties at once.
    plan_add(query_known(6'd63, 6'd0, 6'd63, 1'b0));
    plan_add(load_w(6'd0, '0));
    plan_add(load_w(6'd63, '1));
    plan_add(query_w(6'd63, 6'd0, 6'd1));
    // Path 1 -> 2 -> 3 -> 62, then closed into a cycle back to 1.
    plan_add(load_w(6'd1, bit_at(2)));
    plan_add(load_w(6'd2, bit_at(3)));
    plan_add(load_w(6'd3, bit_at(62)));
    plan_add(query_w(6'd1, 6'd62, 6'd3));
    plan_add(query_w(6'd1, 6'd62, 6'd2));
    plan_add(load_w(6'd62, bit_at(1)));
    plan_add(query_w(6'd1, 6'd5, 6'd63));
    plan_add(query_w(6'd2, 6'd1, 6'd3));
    plan_add(load_w(6'd63, '0));
    plan_add(load_w(6'd1, 64'hAAAA_AAAA_AAAA_AAAA));
    plan_add(load_w(6'd2, 64'h5555_5555_5555_5555));
    plan_add(query_w(6'd1, 6'd2, 6'd1));
    plan_add(query_w(6'd1, 6'd2, 6'd63));
    plan_add(query_w(6'd0, 6'd63, 6'd63));

    wait (rst_ni);
    @(negedge clk_i);
    sent = 0;
    burst_left = 0;
    while (sent < WordTarget) begin
      if (word_plan.size() == 0) plan_group();
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 20);
      end
      cur_word = word_plan.pop_front();
      in_valid_i = 1'b1;
      // Hold the word until a rising edge takes it.
      do @(negedge clk_i); while (!in_took);
      sent++;
      burst_left--;
    end
    in_valid_i = 1'b0;

    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("tb: %0d loads and %0d queries taken, %0d answered reachable, %0d not",
             loads_taken, queries_taken, hits, misses);
    $display("tb: longest input stall %0d cycles, %0d failures", stall_max, errors);
    if (errors == 0) begin
      $display("tb_hop_limited_reachability: done, clean");
    end else begin
      $display("tb_hop_limited_reachability: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
design/hlr_pkg.sv
design/hlr_ctrl.sv
design/hlr_dp.sv
design/hop_limited_reachability.sv
dv/tb_hop_limited_reachability.sv
